FILE: rtl/slp_pkg.sv
// Shared types, constants and helpers for the slice list text parser.
package slp_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned LIMIT_W      = 20;
  localparam int unsigned STEP_W       = 24;
  localparam int unsigned DCNT_W       = 4;
  localparam int unsigned BCNT_W       = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned MAX_DIGITS_DEF = 7;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned OVERFLOW_VALUE = 1000000;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd64;

  // Register word index (paddr[2])
  localparam logic REG_RANGE_LIMIT = 1'b0;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

  // Closed segment summary handed from front to back
  typedef struct packed {
    logic       ok;
    logic       last;
    logic [1:0] seps;
  } seg_ctrl_t;

  localparam int unsigned SEG_CTRL_W = $bits(seg_ctrl_t);

  // Field accumulator width: holds the largest kept value and the step output
  function automatic int unsigned field_width(input int unsigned digits);
    int unsigned w;
    w = $clog2(10 ** digits);
    return (w < STEP_W) ? STEP_W : w;
  endfunction

endpackage

FILE: rtl/slp_chan_if.sv
// Valid/ready channel interfaces for characters in and slices out.
interface slp_in_if;
  logic                         valid;
  logic                         ready;
  logic [slp_pkg::CHAR_W-1:0]   char_code;
  logic                         text_end;

  modport source (output valid, output char_code, output text_end, input ready);
  modport sink   (input valid, input char_code, input text_end, output ready);
endinterface

interface slp_out_if;
  logic                         valid;
  logic                         ready;
  logic [slp_pkg::LIMIT_W-1:0]  slice_start;
  logic [slp_pkg::LIMIT_W-1:0]  slice_end;
  logic [slp_pkg::STEP_W-1:0]   slice_step;
  logic                         slice_valid;
  logic                         list_end;

  modport source (output valid, output slice_start, output slice_end, output slice_step,
                  output slice_valid, output list_end, input ready);
  modport sink   (input valid, input slice_start, input slice_end, input slice_step,
                  input slice_valid, input list_end, output ready);
endinterface

FILE: rtl/slp_front.sv
// Front end: classifies characters, accumulates segment fields, closes segments.
module slp_front #(
  parameter int unsigned MAX_DIGITS = 7,
  parameter int unsigned FIELD_W    = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  slp_in_if.sink                     in_bus,
  input  logic                       q_full,
  output logic                       q_push,
  output slp_pkg::seg_ctrl_t         rec_ctrl,
  output logic [2:0][FIELD_W-1:0]    rec_field
);
  import slp_pkg::*;

  typedef enum logic [2:0] {
    CL_DIGIT, CL_RANGE, CL_SPACE, CL_OPEN, CL_CLOSE, CL_SEP, CL_BAD
  } char_class_t;

  localparam logic [DCNT_W-1:0] DCNT_SAT = '1;
  localparam logic [DCNT_W-1:0] DCNT_MAX = DCNT_W'(MAX_DIGITS);
  localparam logic [BCNT_W-1:0] BCNT_SAT = '1;

  logic [2:0][FIELD_W-1:0] val_r, val_nxt;
  logic [2:0][DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BCNT_W-1:0]       seps_r, seps_nxt;
  logic [BCNT_W-1:0]       open_r, open_nxt;
  logic [BCNT_W-1:0]       close_r, close_nxt;
  logic                    bad_r, bad_nxt;
  logic                    content_r, content_nxt;

  char_class_t             cls;
  logic [CHAR_W-1:0]       c;
  logic [1:0]              fsel;
  logic [FIELD_W-1:0]      digit;
  logic                    accept;
  logic                    close_evt;
  logic                    seg_ok;

  assign c         = in_bus.char_code;
  assign accept    = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !q_full;
  assign fsel      = (seps_r == BCNT_SAT) ? 2'd2 : seps_r;
  assign digit     = FIELD_W'(c[3:0]);

  always_comb begin
    priority if (c >= CH_ZERO && c <= CH_NINE)                    cls = CL_DIGIT;
    else if (c == CH_DASH || c == CH_COLON)                       cls = CL_RANGE;
    else if (c == CH_SPACE)                                       cls = CL_SPACE;
    else if (c == CH_LBRACK || c == CH_LBRACE || c == CH_LPAREN)  cls = CL_OPEN;
    else if (c == CH_RBRACK || c == CH_RBRACE || c == CH_RPAREN)  cls = CL_CLOSE;
    else if (c == CH_COMMA || c == CH_SEMI)                       cls = CL_SEP;
    else                                                          cls = CL_BAD;
  end

  // Segment state after this character (a separator leaves it as is)
  always_comb begin
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    seps_nxt    = seps_r;
    open_nxt    = open_r;
    close_nxt   = close_r;
    bad_nxt     = bad_r;
    content_nxt = content_r;
    unique case (cls)
      CL_DIGIT: begin
        for (int i = 0; i < 3; i++) begin
          if (fsel == 2'(i)) begin
            if (cnt_r[i] < DCNT_MAX)
              val_nxt[i] = (val_r[i] << 3) + (val_r[i] << 1) + digit;
            if (cnt_r[i] != DCNT_SAT)
              cnt_nxt[i] = cnt_r[i] + 1'b1;
          end
        end
        content_nxt = 1'b1;
      end
      CL_RANGE: begin
        if (seps_r != BCNT_SAT)
          seps_nxt = seps_r + 1'b1;
        content_nxt = 1'b1;
      end
      CL_OPEN: begin
        if (open_r != BCNT_SAT)
          open_nxt = open_r + 1'b1;
      end
      CL_CLOSE: begin
        if (close_r != BCNT_SAT)
          close_nxt = close_r + 1'b1;
      end
      CL_BAD:   bad_nxt = 1'b1;
      CL_SPACE, CL_SEP: ;
      default: ;
    endcase
  end

  assign close_evt = (cls == CL_SEP) || in_bus.text_end;
  assign seg_ok    = !bad_nxt && (open_nxt == close_nxt) && (open_nxt <= BCNT_W'(1))
                     && content_nxt && (seps_nxt <= BCNT_W'(2));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rec_field[i] = (cnt_nxt[i] > DCNT_MAX) ? FIELD_W'(OVERFLOW_VALUE) : val_nxt[i];
    end
  end

  assign rec_ctrl.ok   = seg_ok;
  assign rec_ctrl.last = in_bus.text_end;
  assign rec_ctrl.seps = seps_nxt;

  // Drop invalid segments here unless the beat ends the list
  assign q_push = accept && close_evt && (seg_ok || in_bus.text_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r     <= '0;
      cnt_r     <= '0;
      seps_r    <= '0;
      open_r    <= '0;
      close_r   <= '0;
      bad_r     <= 1'b0;
      content_r <= 1'b0;
    end else if (accept) begin
      if (close_evt) begin
        val_r     <= '0;
        cnt_r     <= '0;
        seps_r    <= '0;
        open_r    <= '0;
        close_r   <= '0;
        bad_r     <= 1'b0;
        content_r <= 1'b0;
      end else begin
        val_r     <= val_nxt;
        cnt_r     <= cnt_nxt;
        seps_r    <= seps_nxt;
        open_r    <= open_nxt;
        close_r   <= close_nxt;
        bad_r     <= bad_nxt;
        content_r <= content_nxt;
      end
    end
  end

endmodule

FILE: rtl/slp_queue.sv
// Small FIFO between the front and back ends.
module slp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);
  import slp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_data = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full)
      mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full)
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop && !empty)
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      unique case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/slp_back.sv
// Back end: applies defaults and range checks, holds the result register.
module slp_back #(
  parameter int unsigned FIELD_W = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  slp_pkg::seg_ctrl_t            head_ctrl,
  input  logic [2:0][FIELD_W-1:0]       head_field,
  input  logic [slp_pkg::LIMIT_W-1:0]   range_limit,
  output logic                          q_pop,
  slp_out_if.source                     out_bus
);
  import slp_pkg::*;

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1);

  logic                 out_valid_r;
  logic [LIMIT_W-1:0]   start_r, end_r;
  logic [STEP_W-1:0]    step_r;
  logic                 slice_valid_r, list_end_r;

  logic [FIELD_W-1:0]   lim, a, b, k, a_d, b_d, k_d;
  logic [FIELD_W-1:0]   s_val, e_val, st_val;
  logic                 range_ok, res_ok, emit;

  assign lim = FIELD_W'(range_limit);
  assign a   = head_field[0];
  assign b   = (head_ctrl.seps == 2'd1) ? head_field[1] : head_field[2];
  assign k   = (head_ctrl.seps == 2'd1) ? ONE : head_field[1];
  assign a_d = (a == '0) ? ONE : a;
  assign b_d = (b == '0) ? lim : b;
  assign k_d = (k == '0) ? ONE : k;

  always_comb begin
    if (head_ctrl.seps == 2'd0) begin
      range_ok = (a != '0) && (a <= lim);
      s_val    = a - ONE;
      e_val    = a - ONE;
      st_val   = ONE;
    end else begin
      range_ok = (a_d <= b_d) && (b_d <= lim);
      s_val    = a_d - ONE;
      e_val    = b_d - ONE;
      st_val   = k_d;
    end
  end

  assign res_ok = head_ctrl.ok && range_ok;
  assign emit   = res_ok || head_ctrl.last;
  assign q_pop  = !q_empty && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= emit;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Bare end marks carry zero payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_r       <= res_ok ? s_val[LIMIT_W-1:0] : '0;
      end_r         <= res_ok ? e_val[LIMIT_W-1:0] : '0;
      step_r        <= res_ok ? st_val[STEP_W-1:0] : '0;
      slice_valid_r <= res_ok;
      list_end_r    <= head_ctrl.last;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.slice_start = start_r;
  assign out_bus.slice_end   = end_r;
  assign out_bus.slice_step  = step_r;
  assign out_bus.slice_valid = slice_valid_r;
  assign out_bus.list_end    = list_end_r;

endmodule

FILE: rtl/slice_list_text_parser.sv
// Slice list text parser: top level with the range limit register.
//
//   port      dir   handshake           contents
//   in_bus    in    valid/ready         char_code, text_end
//   out_bus   out   valid/ready         slice_start, slice_end, slice_step, slice_valid, list_end
//   cfg_*     in    APB write/read      range_limit at byte address 0
//
// One character is taken every cycle while the FIFO is not full; the front end updates the
// segment state with a shift-and-add multiply by ten.
// A closing beat enters the front-to-back FIFO at its accepting edge; the back end checks
// the head and loads the result register once out_bus is free, raising out_bus.valid unless
// the range check fails on a segment that does not end the list.
// Reset is synchronous; it clears the segment state, the FIFO and the output valid.
// in_bus stalls only when the two-entry FIFO is full, which takes out_bus held back.
module slice_list_text_parser #(
  parameter int unsigned MAX_DIGITS = slp_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  slp_in_if.sink                          in_bus,
  slp_out_if.source                       out_bus,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [slp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [slp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [slp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import slp_pkg::*;

  localparam int unsigned FIELD_W = field_width(MAX_DIGITS);
  localparam int unsigned REC_W   = SEG_CTRL_W + 3 * FIELD_W;

  logic [LIMIT_W-1:0]       limit_r;
  logic                     cfg_wr;

  logic                     q_push, q_pop, q_full, q_empty;
  seg_ctrl_t                rec_ctrl, head_ctrl;
  logic [2:0][FIELD_W-1:0]  rec_field, head_field;
  logic [REC_W-1:0]         head_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_RANGE_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_RANGE_LIMIT) begin
      limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  slp_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .FIELD_W    (FIELD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .q_full    (q_full),
    .q_push    (q_push),
    .rec_ctrl  (rec_ctrl),
    .rec_field (rec_field)
  );

  slp_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({rec_ctrl, rec_field}),
    .pop       (q_pop),
    .head_data (head_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign head_ctrl  = head_data[REC_W-1 -: SEG_CTRL_W];
  assign head_field = head_data[3*FIELD_W-1:0];

  slp_back #(
    .FIELD_W (FIELD_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head_ctrl   (head_ctrl),
    .head_field  (head_field),
    .range_limit (limit_r),
    .q_pop       (q_pop),
    .out_bus     (out_bus)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("segment record pushed into a full queue");

  a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.slice_valid) |->
      (out_bus.slice_start == '0 && out_bus.slice_end == '0 && out_bus.slice_step == '0
       && out_bus.list_end))
    else $error("bare result without end mark or with nonzero payload");

  a_slice_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.slice_valid) |->
      (out_bus.slice_start <= out_bus.slice_end && out_bus.slice_step != '0))
    else $error("slice result with start past end or zero step");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_ctrl.last) |=> out_bus.valid && out_bus.list_end)
    else $error("list end record did not reach the output");
`endif

endmodule

FILE: tb/tb_slice_list_text_parser.sv
// Testbench for the slice list text parser: directed and random text, checked by a predictor.
`timescale 1ns / 1ps

module tb_slice_list_text_parser;
  import slp_pkg::*;

  typedef struct packed {
    logic [LIMIT_W-1:0] first_idx;
    logic [LIMIT_W-1:0] last_idx;
    logic [STEP_W-1:0]  stride;
    logic               valid;
    logic               list_end;
  } slice_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              fixed;
    slice_t            want;
  } plan_row_t;

  localparam slice_t NO_SLICE = '0;
  localparam slice_t END_MARK = {20'd0, 20'd0, 24'd0, 1'b0, 1'b1};
  localparam slice_t FULL_64  = {20'd0, 20'd63, 24'd1, 1'b1, 1'b1};
  localparam logic [CFG_ADDR_W-1:0] ADDR_RANGE_LIMIT = {REG_RANGE_LIMIT, 2'b00};
  localparam logic [CHAR_W-1:0] OPENERS [3] = '{CH_LBRACK, CH_LBRACE, CH_LPAREN};
  localparam logic [CHAR_W-1:0] CLOSERS [3] = '{CH_RBRACK, CH_RBRACE, CH_RPAREN};
  localparam int N_PLAN = 29;

  // Expected values typed in only on final characters, where they read off directly.
  localparam plan_row_t PLAN [N_PLAN] = '{
    {CH_ZERO + 8'd5, 1'b1, 1'b1, {20'd4, 20'd4, 24'd1, 1'b1, 1'b1}},
    {CH_ZERO + 8'd1, 1'b0, 1'b0, NO_SLICE},
    {CH_DASH,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO + 8'd6, 1'b0, 1'b0, NO_SLICE},
    {CH_ZERO + 8'd4, 1'b1, 1'b1, FULL_64},
    {CH_LPAREN,      1'b0, 1'b0, NO_SLICE},
    {CH_ZERO + 8'd2, 1'b0, 1'b0, NO_SLICE},
    {CH_COLON,       1'b0, 1'b0, NO_SLICE},
    {CH_ZERO + 8'd3, 1'b0, 1'b0, NO_SLICE},
    {CH_COLON,       1'b0, 1'b0, NO_SLICE},
    {CH_RPAREN,      1'b1, 1'b1, {20'd1, 20'd63, 24'd3, 1'b1, 1'b1}},
    {CH_SPACE,       1'b0, 1'b0, NO_SLICE},
    {CH_DASH,        1'b1, 1'b1, FULL_64},
    {CH_ZERO + 8'd3, 1'b0, 1'b0, NO_SLICE},
    {CH_RBRACE,      1'b1, 1'b1, END_MARK},
    {CH_COMMA,       1'b1, 1'b1, END_MARK},
    {CH_DASH,        1'b0, 1'b0, NO_SLICE},
    {CH_COLON,       1'b0, 1'b0, NO_SLICE},
    {CH_DASH,        1'b1, 1'b1, END_MARK},
    {CH_ZERO,        1'b1, 1'b1, END_MARK},
    {8'hFF,          1'b1, 1'b1, END_MARK},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO,        1'b0, 1'b0, NO_SLICE},
    {CH_ZERO + 8'd1, 1'b1, 1'b1, END_MARK}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  slp_in_if  in_if ();
  slp_out_if out_if ();

  slice_list_text_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_if),
    .out_bus     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Predictor copy of the limit register and the segment state
  logic [LIMIT_W-1:0] lim_q;
  logic [STEP_W-1:0]  fld_val [3];
  logic [DCNT_W-1:0]  fld_cnt [3];
  logic [1:0]         sep_cnt;
  logic [BCNT_W-1:0]  open_cnt;
  logic [BCNT_W-1:0]  close_cnt;
  logic               bad_seen;
  logic               content;

  slice_t            slices_due [$];
  logic [CHAR_W-1:0] text_q [$];
  bit                rush;
  int unsigned       n_chars, n_lists, n_slices, n_marks, n_writes, n_errors;

  function automatic void clear_seg();
    for (int i = 0; i < 3; i++) begin
      fld_val[i] = '0;
      fld_cnt[i] = '0;
    end
    sep_cnt   = '0;
    open_cnt  = '0;
    close_cnt = '0;
    bad_seen  = 1'b0;
    content   = 1'b0;
  endfunction

  function automatic logic [STEP_W-1:0] field_at(int i);
    return (fld_cnt[i] > MAX_DIGITS_DEF) ? STEP_W'(OVERFLOW_VALUE) : fld_val[i];
  endfunction

  function automatic bit close_seg(output slice_t r);
    logic [STEP_W-1:0] a, b, k;
    logic [1:0]        s;
    bit                ok;
    r  = '0;
    ok = !bad_seen && open_cnt == close_cnt && open_cnt <= 1 && content && sep_cnt <= 2;
    s  = sep_cnt;
    a  = field_at(0);
    b  = field_at(1);
    k  = 24'd1;
    if (s == 2'd2) begin
      k = field_at(1);
      b = field_at(2);
    end
    clear_seg();
    if (!ok) return 0;
    if (s == 2'd0) begin
      if (a == 0 || a > lim_q) return 0;
      b = a;
    end else begin
      if (a == 0) a = 24'd1;
      if (b == 0) b = lim_q;
      if (k == 0) k = 24'd1;
      if (a > b || a > lim_q || b > lim_q) return 0;
    end
    r.first_idx = LIMIT_W'(a - 24'd1);
    r.last_idx  = LIMIT_W'(b - 24'd1);
    r.stride    = k;
    r.valid     = 1'b1;
    return 1;
  endfunction

  function automatic void take_char(logic [CHAR_W-1:0] c);
    logic [1:0] f;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      f = (sep_cnt > 2) ? 2'd2 : sep_cnt;
      if (fld_cnt[f] < MAX_DIGITS_DEF) fld_val[f] = fld_val[f] * 10 + (c - CH_ZERO);
      if (fld_cnt[f] < 15) fld_cnt[f] = fld_cnt[f] + 1'b1;
      content = 1'b1;
    end else if (c == CH_DASH || c == CH_COLON) begin
      if (sep_cnt < 3) sep_cnt = sep_cnt + 1'b1;
      content = 1'b1;
    end else if (c == CH_SPACE) begin
    end else if (c == CH_LBRACK || c == CH_LBRACE || c == CH_LPAREN) begin
      if (open_cnt < 3) open_cnt = open_cnt + 1'b1;
    end else if (c == CH_RBRACK || c == CH_RBRACE || c == CH_RPAREN) begin
      if (close_cnt < 3) close_cnt = close_cnt + 1'b1;
    end else begin
      bad_seen = 1'b1;
    end
  endfunction

  // Advance the parser by one character; returns 1 when a result is due.
  function automatic bit parse_char(logic [CHAR_W-1:0] c, logic last, output slice_t r);
    bit got;
    got = 0;
    r   = '0;
    if (c == CH_COMMA || c == CH_SEMI) got = close_seg(r);
    else take_char(c);
    if (last) begin
      if (!got) got = close_seg(r);
      else clear_seg();
      if (!got) r = '0;
      r.list_end = 1'b1;
      return 1;
    end
    return got;
  endfunction

  // Random text generation
  function automatic int unsigned pick_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return lim_q;
      2: return lim_q + 1;
      3: return $urandom_range(0, 9999999);
      default: return (lim_q == 0) ? $urandom_range(1, 3) : $urandom_range(1, lim_q);
    endcase
  endfunction

  function automatic void push_digits(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_field(int unsigned v);
    case ($urandom_range(0, 11))
      0: ;
      1: repeat ($urandom_range(8, 17)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      2: begin
        repeat ($urandom_range(1, 9)) text_q.push_back(CH_ZERO);
        push_digits(v);
      end
      3: begin
        push_digits($urandom_range(0, 9));
        text_q.push_back(CH_SPACE);
        push_digits($urandom_range(0, 99));
      end
      default: push_digits(v);
    endcase
    if ($urandom_range(0, 7) == 0) text_q.push_back(CH_SPACE);
  endfunction

  function automatic void add_segment();
    int unsigned nf, a, b, t, sel, base;
    bit br;
    base = text_q.size();
    sel  = $urandom_range(0, 19);
    nf   = (sel < 6) ? 1 : (sel < 13) ? 2 : (sel < 19) ? 3 : 4;
    a    = pick_value();
    b    = pick_value();
    if (a > b && $urandom_range(0, 2) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    br = ($urandom_range(0, 3) == 0);
    if (br) text_q.push_back(OPENERS[$urandom_range(0, 2)]);
    push_field(a);
    for (int f = 1; f < nf; f++) begin
      text_q.push_back($urandom_range(0, 1) ? CH_DASH : CH_COLON);
      if (f == nf - 1) push_field(b);
      else push_field(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999999)
                                                  : $urandom_range(0, 10));
    end
    if (br) text_q.push_back(CLOSERS[$urandom_range(0, 2)]);
    // Break the segment now and then: stray byte, stray bracket, extra space
    case ($urandom_range(0, 11))
      0: text_q.insert($urandom_range(base, text_q.size()), 8'($urandom_range(0, 255)));
      1: text_q.insert($urandom_range(base, text_q.size()), OPENERS[$urandom_range(0, 2)]);
      2: text_q.insert($urandom_range(base, text_q.size()), CLOSERS[$urandom_range(0, 2)]);
      3: text_q.insert($urandom_range(base, text_q.size()), CH_SPACE);
      default: ;
    endcase
  endfunction

  function automatic void build_list();
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = $urandom_range(1, 4); i > 0; i--) begin
        add_segment();
        if (i > 1) begin
          text_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
          if ($urandom_range(0, 2) == 0) text_q.push_back(CH_SPACE);
        end
      end
      if ($urandom_range(0, 7) == 0) text_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
    end
    if (text_q.size() == 0) text_q.push_back(CH_SPACE);
  endfunction

  task automatic feed_char(logic [CHAR_W-1:0] c, logic last, logic fixed, slice_t want);
    int unsigned gap;
    slice_t      r;
    bit          got;
    gap = rush ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.text_end  <= last;
    do @(posedge clk); while (!in_if.ready);
    got = parse_char(c, last, r);
    if (got) slices_due.push_back(fixed ? want : r);
    n_chars++;
    if (last) n_lists++;
  endtask

  // Drop valid, drain the expected slices and let the pipeline empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (slices_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_RANGE_LIMIT;
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    lim_q = v;
    n_writes++;
    // Read back in the following transfer
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[LIMIT_W-1:0] !== v) begin
      n_errors++;
      $display("%0t range_limit read expected %0d got %0d", $time, v, cfg_prdata[LIMIT_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic void check_field(string what, longint unsigned want, longint unsigned seen);
    if (want != seen) begin
      n_errors++;
      $display("%0t %s expected %0d got %0d", $time, what, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    slice_t seen, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = {out_if.slice_start, out_if.slice_end, out_if.slice_step,
              out_if.slice_valid, out_if.list_end};
      if (slices_due.size() == 0) begin
        n_errors++;
        $display("%0t result expected none got start %0d end %0d step %0d valid %0b end %0b",
                 $time, seen.first_idx, seen.last_idx, seen.stride, seen.valid, seen.list_end);
      end else begin
        want = slices_due.pop_front();
        check_field("slice_start", want.first_idx, seen.first_idx);
        check_field("slice_end", want.last_idx, seen.last_idx);
        check_field("slice_step", want.stride, seen.stride);
        check_field("slice_valid", want.valid, seen.valid);
        check_field("list_end", want.list_end, seen.list_end);
        if (want.valid) n_slices++;
        else n_marks++;
      end
    end
  end

  // Result side: stall a random number of cycles before each beat
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL slice_list_text_parser");
    $finish;
  end

  initial begin
    logic [LIMIT_W-1:0] setting [6];
    int unsigned        mark;
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    in_if.text_end  <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    rush  = 0;
    lim_q = LIMIT_RESET;
    clear_seg();
    setting = '{LIMIT_RESET, 20'd1000000, 20'd0, 20'd1, 20'($urandom_range(2, 200)),
                20'($urandom_range(0, 1000000))};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_PLAN; i++) feed_char(PLAN[i].ch, PLAN[i].last, PLAN[i].fixed, PLAN[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        write_limit(setting[ph]);
      end
      mark = n_chars;
      while (n_chars - mark < 125) begin
        rush = ($urandom_range(0, 3) == 0);
        build_list();
        for (int i = 0; i < text_q.size(); i++)
          feed_char(text_q[i], i == text_q.size() - 1, 1'b0, NO_SLICE);
      end
    end
    rush = 0;
    settle();
    repeat (10) @(posedge clk);

    $display("Fed %0d characters in %0d lists across %0d range limit writes",
             n_chars, n_lists, n_writes);
    $display("Compared %0d slices and %0d bare end marks, %0d mismatches",
             n_slices, n_marks, n_errors);
    if (n_errors == 0) begin
      $display("PASS slice_list_text_parser");
    end else begin
      $display("FAIL slice_list_text_parser");
    end
    $finish;
  end

endmodule
